// ===== src/polyphonic_wavetable_synth_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the polyphonic wavetable synthesizer
// Short forms for clocked checks that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_WAVETABLE_SYNTH_ASSERT_SVH
`define POLYPHONIC_WAVETABLE_SYNTH_ASSERT_SVH

// Same-cycle implication.
`define PWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pwsynth_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsynth_pkg
// Shared constants, command codes, control struct and table builders.
// ----------------------------------------------------------------------------
package pwsynth_pkg;

    // Fixed number formats.
    localparam int LVL_F      = 16;
    localparam int LVL_W      = LVL_F + 1;
    localparam int FAC_W      = LVL_F;
    localparam int PHASE_FRAC = 16;
    localparam int NOTE_W     = 7;
    localparam int CMD_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LVL_W;
    localparam int ACC_W      = 42;
    localparam int MIX_W      = ACC_W - LVL_F;
    localparam int SCALED_W   = MIX_W + LVL_W + 1;
    localparam int OUT_LIMIT  = 32111;
    localparam int PIPE_DRAIN = 4;
    localparam int SAMPLE_RATE_HZ = 22050;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ON   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OFF  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd5;

    // Register reset values.
    localparam logic [LVL_W-1:0] RST_ATTACK  = 17'd1180;
    localparam logic [FAC_W-1:0] RST_DECAY   = 16'd65497;
    localparam logic [LVL_W-1:0] RST_SUSTAIN = 17'd24904;
    localparam logic [FAC_W-1:0] RST_RELEASE = 16'd64946;
    localparam logic [LVL_W-1:0] RST_FLOOR   = 17'd66;
    localparam logic [LVL_W-1:0] RST_GAIN    = 17'd14418;

    // Equal-tempered semitone ratios in Q16.
    localparam int unsigned SEMITONE [12] = '{
        65536, 69433, 73562, 77936, 82570, 87480,
        92682, 98193, 104032, 110218, 116772, 123716
    };

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Controller to datapath commands.
    typedef struct packed {
        logic              note_on;
        logic              gate_close;
        logic              clear_acc;
        logic              issue;
        logic [NOTE_W-1:0] vidx;
        logic              mix_en;
        logic              scale_en;
        logic              load_out;
    } ctrl_cmd_t;

    // Sine of one table index in signed Q30, for a power-of-two table depth.
    function automatic longint signed sine_q30(input longint unsigned idx, input int wbits);
        longint unsigned dmask;
        longint unsigned p;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        dmask = (64'd1 << wbits) - 64'd1;
        p     = (idx & dmask) * 64'd4;
        quad  = p >> wbits;
        r     = p & dmask;
        if (quad[0])
        begin
            r = (64'd1 << wbits) - r;
        end
        x  = (HALF_PI_Q30 * r) >> wbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        return (quad >= 64'd2) ? -longint'(s) : longint'(s);
    endfunction

    // One entry of the harmonic wave table.
    function automatic logic signed [SAMPLE_W-1:0] wave_value(input longint unsigned idx,
                                                              input int wbits);
        longint signed w;
        w = sine_q30(idx, wbits);
        w = w + sine_q30(idx * 2, wbits) * 64'sd20972 / 64'sd65536;
        w = w + sine_q30(idx * 3, wbits) * 64'sd7864 / 64'sd65536;
        w = w + sine_q30(idx * 5, wbits) * 64'sd3277 / 64'sd65536;
        w = w * 64'sd40632 / 64'sd65536;
        return SAMPLE_W'(w * 64'sd32767 / 64'sd1073741824);
    endfunction

endpackage

// ===== src/pwsynth_ram.sv =====
// ----------------------------------------------------------------------------
// pwsynth_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pwsynth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/pwsynth_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwsynth_ctrl
// Sequencer: takes words, walks the voices on a tick and hands out results.
// ----------------------------------------------------------------------------
module pwsynth_ctrl #(
    parameter int VOICE_COUNT = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [pwsynth_pkg::CMD_W-1:0]       cmd,
    output logic                                in_stall,
    output logic                                out_valid,
    input  logic                                out_stall,
    output pwsynth_pkg::ctrl_cmd_t              ctl
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_MIX   = 6'b001000,
        S_SCALE = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [pwsynth_pkg::NOTE_W-1:0]  vidx_reg;
    logic [pwsynth_pkg::NOTE_W-1:0]  vidx_next;
    logic [2:0]                      drain_reg;
    logic [2:0]                      drain_next;
    logic                            out_valid_reg;
    logic                            accept;
    logic                            last_voice;
    logic                            out_free;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign last_voice = (vidx_reg == pwsynth_pkg::NOTE_W'(VOICE_COUNT - 1));
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        vidx_next     = vidx_reg;
        drain_next    = drain_reg;
        ctl           = '0;
        ctl.vidx      = vidx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.note_on    = (cmd == pwsynth_pkg::CMD_ON);
                    ctl.gate_close = (cmd == pwsynth_pkg::CMD_OFF);
                    if (cmd == pwsynth_pkg::CMD_TICK)
                    begin
                        ctl.clear_acc = 1'b1;
                        vidx_next     = '0;
                        state_next    = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                ctl.issue = 1'b1;
                if (last_voice)
                begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 3'(pwsynth_pkg::PIPE_DRAIN - 1))
                begin
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                ctl.mix_en = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                ctl.scale_en = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vidx_reg      <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vidx_reg  <= vidx_next;
            drain_reg <= drain_next;
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/pwsynth_dp.sv =====
// ----------------------------------------------------------------------------
// pwsynth_dp
// Voice datapath: settings, voice state, envelope pipeline, mixer and output.
// ----------------------------------------------------------------------------
module pwsynth_dp #(
    parameter int VOICE_COUNT = 128,
    parameter int WAVE_DEPTH  = 2048
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  pwsynth_pkg::ctrl_cmd_t                   ctl,
    input  logic [pwsynth_pkg::NOTE_W-1:0]           note,
    input  logic                                     cfg_we,
    input  logic [pwsynth_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pwsynth_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic signed [pwsynth_pkg::SAMPLE_W-1:0]  sample
);

    localparam int VW        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int WAVE_BITS = $clog2(WAVE_DEPTH);
    localparam int PW        = WAVE_BITS + pwsynth_pkg::PHASE_FRAC;
    localparam int LW        = pwsynth_pkg::LVL_W;
    localparam int FW        = pwsynth_pkg::FAC_W;
    localparam int RW        = PW + LW;
    localparam int PROD_W    = pwsynth_pkg::SAMPLE_W + LW + 1;
    localparam logic [LW:0]  LVL_ONE = (LW + 1)'(1) << pwsynth_pkg::LVL_F;

    // Settings.
    logic [LW-1:0] attack_step_reg;
    logic [FW-1:0] decay_factor_reg;
    logic [LW-1:0] sustain_level_reg;
    logic [FW-1:0] release_factor_reg;
    logic [LW-1:0] release_floor_reg;
    logic [LW-1:0] master_gain_reg;

    // Per-voice flags.
    logic [VOICE_COUNT-1:0] active_reg;
    logic [VOICE_COUNT-1:0] gate_reg;
    logic [VOICE_COUNT-1:0] attack_reg;

    // Constant tables.
    logic [PW-1:0]                           step_tbl [VOICE_COUNT];
    logic signed [pwsynth_pkg::SAMPLE_W-1:0] wave_tbl [WAVE_DEPTH];

    // Pipeline.
    logic [VW-1:0]  note_idx;
    logic           note_ok;
    logic [VW-1:0]  rd_idx;
    logic [RW-1:0]  rd_data;
    logic           p1_valid_reg;
    logic [VW-1:0]  p1_v_reg;
    logic           p1_gate_reg;
    logic           p1_attack_reg;
    logic [LW-1:0]  lvl1;
    logic [LW:0]    sum1;
    logic [FW-1:0]  fac1;
    logic [LW+FW-1:0] prod1;
    logic           p2_valid_reg;
    logic [VW-1:0]  p2_v_reg;
    logic           p2_gate_reg;
    logic           p2_attack_reg;
    logic [LW-1:0]  p2_lvl_reg;
    logic [LW:0]    p2_sum_reg;
    logic [LW-1:0]  p2_scaled_reg;
    logic [PW-1:0]  p2_phase_reg;
    logic [LW-1:0]  lvl2;
    logic           sound2;
    logic           free2;
    logic           clr_attack2;
    logic           ram_we;
    logic [VW-1:0]  ram_waddr;
    logic [RW-1:0]  ram_wdata;
    logic           p3_valid_reg;
    logic [LW-1:0]  p3_lvl_reg;
    logic signed [pwsynth_pkg::SAMPLE_W-1:0] p3_wave_reg;
    logic           p4_valid_reg;
    logic signed [PROD_W-1:0] p4_prod_reg;

    // Mixer.
    logic signed [pwsynth_pkg::ACC_W-1:0]    acc_reg;
    logic signed [pwsynth_pkg::ACC_W-1:0]    acc_adj;
    logic signed [pwsynth_pkg::MIX_W-1:0]    mix_reg;
    logic signed [pwsynth_pkg::SCALED_W-1:0] scaled_reg;
    logic signed [pwsynth_pkg::SCALED_W-1:0] scaled_adj;
    logic signed [pwsynth_pkg::SCALED_W-pwsynth_pkg::LVL_F-1:0] clip_in;
    logic signed [pwsynth_pkg::SAMPLE_W-1:0] sample_reg;

    // Phase increments per note.
    for (genvar g = 0; g < VOICE_COUNT; g++)
    begin : g_step
        localparam longint unsigned NUM =
            (longint'(WAVE_DEPTH) * 440 * pwsynth_pkg::SEMITONE[(g + 3) % 12]) << ((g + 3) / 12);
        localparam longint unsigned DEN  = 64 * pwsynth_pkg::SAMPLE_RATE_HZ;
        localparam longint unsigned STEP = (NUM + DEN / 2) / DEN;
        assign step_tbl[g] = PW'(STEP);
    end

    // Harmonic wave table.
    for (genvar g = 0; g < WAVE_DEPTH; g++)
    begin : g_wave
        localparam logic signed [pwsynth_pkg::SAMPLE_W-1:0] WV =
            pwsynth_pkg::wave_value(longint'(g), WAVE_BITS);
        assign wave_tbl[g] = WV;
    end

    assign note_idx = note[VW-1:0];
    assign note_ok  = ({1'b0, note} < (pwsynth_pkg::NOTE_W + 1)'(VOICE_COUNT));
    assign rd_idx   = ctl.vidx[VW-1:0];

    // Settings registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg    <= pwsynth_pkg::RST_ATTACK;
            decay_factor_reg   <= pwsynth_pkg::RST_DECAY;
            sustain_level_reg  <= pwsynth_pkg::RST_SUSTAIN;
            release_factor_reg <= pwsynth_pkg::RST_RELEASE;
            release_floor_reg  <= pwsynth_pkg::RST_FLOOR;
            master_gain_reg    <= pwsynth_pkg::RST_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwsynth_pkg::REG_ATTACK:  attack_step_reg    <= cfg_data;
                pwsynth_pkg::REG_DECAY:   decay_factor_reg   <= cfg_data[FW-1:0];
                pwsynth_pkg::REG_SUSTAIN: sustain_level_reg  <= cfg_data;
                pwsynth_pkg::REG_RELEASE: release_factor_reg <= cfg_data[FW-1:0];
                pwsynth_pkg::REG_FLOOR:   release_floor_reg  <= cfg_data;
                pwsynth_pkg::REG_GAIN:    master_gain_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Phase and level store, one entry per voice.
    pwsynth_ram #(
        .WIDTH (RW),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx),
        .rdata (rd_data)
    );

    // Stage 1: stored level arrives; attack sum and envelope product.
    assign lvl1  = rd_data[LW-1:0];
    assign sum1  = {1'b0, lvl1} + {1'b0, attack_step_reg};
    assign fac1  = p1_gate_reg ? decay_factor_reg : release_factor_reg;
    assign prod1 = lvl1 * fac1;

    // Stage 2: new level, free and attack decisions.
    always_comb
    begin
        lvl2        = p2_scaled_reg;
        sound2      = 1'b1;
        free2       = 1'b0;
        clr_attack2 = 1'b0;
        if (p2_gate_reg)
        begin
            if (p2_attack_reg)
            begin
                if (p2_sum_reg >= LVL_ONE)
                begin
                    lvl2        = LVL_ONE[LW-1:0];
                    clr_attack2 = 1'b1;
                end
                else
                begin
                    lvl2 = p2_sum_reg[LW-1:0];
                end
            end
            else if (p2_lvl_reg <= sustain_level_reg)
            begin
                lvl2 = sustain_level_reg;
            end
        end
        else if (p2_scaled_reg < release_floor_reg)
        begin
            sound2 = 1'b0;
            free2  = 1'b1;
        end
    end

    // Store write: a note-on restarts the voice, the walk writes back.
    always_comb
    begin
        ram_we    = p2_valid_reg;
        ram_waddr = p2_v_reg;
        if (sound2)
        begin
            ram_wdata = {p2_phase_reg + step_tbl[p2_v_reg], lvl2};
        end
        else
        begin
            ram_wdata = {p2_phase_reg, LW'(0)};
        end
        if (ctl.note_on && note_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = note_idx;
            ram_wdata = '0;
        end
    end

    // Voice flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            gate_reg   <= '0;
            attack_reg <= '0;
        end
        else
        begin
            if (ctl.note_on && note_ok)
            begin
                active_reg[note_idx] <= 1'b1;
                gate_reg[note_idx]   <= 1'b1;
                attack_reg[note_idx] <= 1'b1;
            end
            if (ctl.gate_close && note_ok)
            begin
                gate_reg[note_idx] <= 1'b0;
            end
            if (p2_valid_reg && free2)
            begin
                active_reg[p2_v_reg] <= 1'b0;
            end
            if (p2_valid_reg && clr_attack2)
            begin
                attack_reg[p2_v_reg] <= 1'b0;
            end
        end
    end

    // Pipeline valid tokens.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= ctl.issue && active_reg[rd_idx];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg && sound2;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        p1_v_reg      <= rd_idx;
        p1_gate_reg   <= gate_reg[rd_idx];
        p1_attack_reg <= attack_reg[rd_idx];
        p2_v_reg      <= p1_v_reg;
        p2_gate_reg   <= p1_gate_reg;
        p2_attack_reg <= p1_attack_reg;
        p2_lvl_reg    <= lvl1;
        p2_sum_reg    <= sum1;
        p2_scaled_reg <= prod1[LW+FW-1:pwsynth_pkg::LVL_F];
        p2_phase_reg  <= rd_data[RW-1:LW];
        p3_lvl_reg    <= lvl2;
        p3_wave_reg   <= wave_tbl[p2_phase_reg[PW-1:pwsynth_pkg::PHASE_FRAC]];
        p4_prod_reg   <= p3_wave_reg * $signed({1'b0, p3_lvl_reg});
    end

    // Voice accumulation.
    always_ff @(posedge clk)
    begin
        if (ctl.clear_acc)
        begin
            acc_reg <= '0;
        end
        else if (p4_valid_reg)
        begin
            acc_reg <= acc_reg + pwsynth_pkg::ACC_W'(p4_prod_reg);
        end
    end

    // Truncate toward zero on both scaling steps, then clamp.
    assign acc_adj    = acc_reg + (acc_reg[pwsynth_pkg::ACC_W-1] ?
                        pwsynth_pkg::ACC_W'(65535) : pwsynth_pkg::ACC_W'(0));
    assign scaled_adj = scaled_reg + (scaled_reg[pwsynth_pkg::SCALED_W-1] ?
                        pwsynth_pkg::SCALED_W'(65535) : pwsynth_pkg::SCALED_W'(0));
    assign clip_in    = scaled_adj[pwsynth_pkg::SCALED_W-1:pwsynth_pkg::LVL_F];

    always_ff @(posedge clk)
    begin
        if (ctl.mix_en)
        begin
            mix_reg <= acc_adj[pwsynth_pkg::ACC_W-1:pwsynth_pkg::LVL_F];
        end
        if (ctl.scale_en)
        begin
            scaled_reg <= mix_reg * $signed({1'b0, master_gain_reg});
        end
        if (ctl.load_out)
        begin
            if (clip_in > $signed((pwsynth_pkg::SCALED_W - pwsynth_pkg::LVL_F)'(
                    pwsynth_pkg::OUT_LIMIT)))
            begin
                sample_reg <= pwsynth_pkg::SAMPLE_W'(pwsynth_pkg::OUT_LIMIT);
            end
            else if (clip_in < -$signed((pwsynth_pkg::SCALED_W - pwsynth_pkg::LVL_F)'(
                    pwsynth_pkg::OUT_LIMIT)))
            begin
                sample_reg <= -pwsynth_pkg::SAMPLE_W'(pwsynth_pkg::OUT_LIMIT);
            end
            else
            begin
                sample_reg <= clip_in[pwsynth_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign sample = sample_reg;

endmodule

// ===== src/polyphonic_wavetable_synth.sv =====
// ----------------------------------------------------------------------------
// polyphonic_wavetable_synth
// Polyphonic wavetable synthesizer with one enveloped voice per note number.
// ----------------------------------------------------------------------------
// A note-on or note-off word is taken in the idle state and gives no output
// word. A tick word walks every voice slot through the envelope and mix
// pipeline, one slot per cycle through the single read port of the voice store,
// then drains the pipeline (S_DRAIN) and mixes, scales and loads the output
// (S_MIX, S_SCALE, S_EMIT). After a tick is taken the input stays stalled until
// its sample word is loaded, and loading waits while an earlier sample is held
// by out_stall. Settings may be written whenever no tick is in progress.
module polyphonic_wavetable_synth #(
    parameter int VOICE_COUNT = 128,
    parameter int WAVE_DEPTH  = 2048
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [pwsynth_pkg::CMD_W-1:0]            cmd,
    input  logic [pwsynth_pkg::NOTE_W-1:0]           note,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [pwsynth_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                     cfg_we,
    input  logic [pwsynth_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pwsynth_pkg::CFG_DATA_W-1:0]       cfg_data
);

`include "polyphonic_wavetable_synth_assert.svh"

    pwsynth_pkg::ctrl_cmd_t ctl;

    // Sequencer.
    pwsynth_ctrl #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // Voice datapath.
    pwsynth_dp #(
        .VOICE_COUNT (VOICE_COUNT),
        .WAVE_DEPTH  (WAVE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .note      (note),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample)
    );

    // A tick word closes the input until its sample is out.
    `PWS_ASSERT_NEXT(a_tick_blocks,
        in_valid && !in_stall && cmd == pwsynth_pkg::CMD_TICK,
        in_stall, "tick did not block input")
    // Note commands never meet the voice walk.
    `PWS_ASSERT_SAME(a_note_no_walk, ctl.note_on || ctl.gate_close,
        !ctl.issue && !in_stall, "note command during walk")
    // A new sample never overwrites one still waiting.
    `PWS_ASSERT_SAME(a_out_free, ctl.load_out, !out_valid || !out_stall, "output overwritten")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Polyphonic wavetable synthesizer testbench
// Drives note-on, note-off, tick and spare words through the input channel
// with random gaps, stalls the sample channel at random, and checks every
// sample word against a cycle-free model of the voices, envelopes and mixer.
// ----------------------------------------------------------------------------
module testbench;

    import pwsynth_pkg::*;

    localparam int VOICES       = 128;
    localparam int TABLE_DEPTH  = 2048;
    localparam int SETTLE_TICKS = 200;
    localparam int PHASE_WORDS  = 250;
    localparam int PHASES       = 7;
    localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // Voice model: envelope, phase and mix of every sounding note.
    class synth_scoreboard;
        bit                 active [VOICES];
        bit                 gate [VOICES];
        bit                 attack [VOICES];
        bit [26:0]          phase [VOICES];
        bit [16:0]          level [VOICES];
        bit signed [15:0]   wave [TABLE_DEPTH];
        bit [26:0]          step [VOICES];
        bit [16:0]          attack_step;
        bit [15:0]          decay_factor;
        bit [16:0]          sustain_level;
        bit [15:0]          release_factor;
        bit [16:0]          release_floor;
        bit [16:0]          master_gain;
        bit signed [15:0]   pending_samples [$];
        int                 errors;

        // Sine of a table index in signed Q30, folded onto a quarter wave.
        function longint signed quarter_sine(longint unsigned idx);
            longint unsigned p;
            longint unsigned quad;
            longint unsigned r;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned s;
            longint unsigned one;
            one  = 64'd1 << 30;
            p    = (idx % TABLE_DEPTH) * 4;
            quad = p / TABLE_DEPTH;
            r    = p % TABLE_DEPTH;
            if (quad[0])
            begin
                r = TABLE_DEPTH - r;
            end
            x  = 64'd1686629713 * r / TABLE_DEPTH;
            x2 = (x * x) >> 30;
            t  = one - x2 / 72;
            t  = one - ((x2 * t) >> 30) / 42;
            t  = one - ((x2 * t) >> 30) / 20;
            t  = one - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            return (quad >= 2) ? -longint'(s) : longint'(s);
        endfunction

        function new();
            longint signed   w;
            longint unsigned n;
            longint unsigned num;
            int unsigned     ratio [12];
            ratio = '{65536, 69433, 73562, 77936, 82570, 87480,
                      92682, 98193, 104032, 110218, 116772, 123716};
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                w = quarter_sine(i);
                w = w + quarter_sine(i * 2) * 20972 / 65536;
                w = w + quarter_sine(i * 3) * 7864 / 65536;
                w = w + quarter_sine(i * 5) * 3277 / 65536;
                w = w * 40632 / 65536;
                wave[i] = 16'(w * 32767 / 64'sd1073741824);
            end
            for (int i = 0; i < VOICES; i++)
            begin
                n   = i + 3;
                num = (64'd2048 * 440 * ratio[n % 12]) << (n / 12);
                step[i] = 27'((num + 64'd705600) / 64'd1411200);
                active[i] = 1'b0;
                gate[i]   = 1'b0;
                attack[i] = 1'b0;
                phase[i]  = '0;
                level[i]  = '0;
            end
            attack_step    = RST_ATTACK;
            decay_factor   = RST_DECAY;
            sustain_level  = RST_SUSTAIN;
            release_factor = RST_RELEASE;
            release_floor  = RST_FLOOR;
            master_gain    = RST_GAIN;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ATTACK:  attack_step    = data;
                REG_DECAY:   decay_factor   = data[15:0];
                REG_SUSTAIN: sustain_level  = data;
                REG_RELEASE: release_factor = data[15:0];
                REG_FLOOR:   release_floor  = data;
                REG_GAIN:    master_gain    = data;
                default: ;
            endcase
        endfunction

        // Apply one accepted input word; a tick queues the sample it produces.
        function void note_input(logic [CMD_W-1:0] c, logic [NOTE_W-1:0] nt);
            longint signed   acc;
            longint signed   s;
            longint unsigned lvl;
            acc = 0;
            case (c)
                CMD_ON:
                begin
                    active[nt] = 1'b1;
                    gate[nt]   = 1'b1;
                    attack[nt] = 1'b1;
                    phase[nt]  = '0;
                    level[nt]  = '0;
                end
                CMD_OFF: gate[nt] = 1'b0;
                CMD_TICK:
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (!active[v])
                            continue;
                        lvl = 64'(level[v]);
                        if (gate[v])
                        begin
                            if (attack[v])
                            begin
                                lvl = lvl + attack_step;
                                if (lvl >= 65536)
                                begin
                                    lvl = 65536;
                                    attack[v] = 1'b0;
                                end
                            end
                            else if (lvl > sustain_level)
                                lvl = (lvl * decay_factor) >> 16;
                            else
                                lvl = 64'(sustain_level);
                        end
                        else
                        begin
                            lvl = (lvl * release_factor) >> 16;
                            if (lvl < release_floor)
                            begin
                                active[v] = 1'b0;
                                level[v]  = '0;
                                continue;
                            end
                        end
                        level[v] = lvl[16:0];
                        acc = acc + longint'(wave[phase[v][26:16]]) * longint'(level[v]);
                        phase[v] = phase[v] + step[v];
                    end
                    s = (acc / 65536) * longint'(master_gain) / 65536;
                    if (s > OUT_LIMIT)
                        s = OUT_LIMIT;
                    if (s < -OUT_LIMIT)
                        s = -OUT_LIMIT;
                    pending_samples.push_back(16'(s));
                end
                default: ;
            endcase
        endfunction

        function void check(logic signed [15:0] got);
            bit signed [15:0] want;
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected sample word: expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            if (got !== want)
            begin
                $display("%0t: sample mismatch: expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [CMD_W-1:0]            cmd = CMD_TICK;
    logic [NOTE_W-1:0]           note = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;
    bit                          idle_on = 1'b1;
    synth_scoreboard             sb = new();

    polyphonic_wavetable_synth u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .note      (note),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit.
    initial
    begin
        #(12 * 2000000);
        $display("testbench failed");
        $finish;
    end

    // Sample monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(sample);
    end

    // Random stall bursts on the sample channel.
    initial
    begin
        forever
        begin
            int n;
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Present one word and hold it until it is taken.
    task automatic send_word(logic [CMD_W-1:0] c, logic [NOTE_W-1:0] nt);
        @(negedge clk);
        in_valid <= 1'b1;
        cmd      <= c;
        note     <= nt;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(c, nt);
    endtask

    task automatic idle_gap(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Writes are consecutive; the caller lowers the enable afterwards.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS)
            @(posedge clk);
    endtask

    task automatic load_settings(int p);
        case (p)
            0:
            begin
                write_reg(REG_ATTACK, RST_ATTACK);
                write_reg(REG_DECAY, CFG_DATA_W'(RST_DECAY));
                write_reg(REG_SUSTAIN, RST_SUSTAIN);
                write_reg(REG_RELEASE, CFG_DATA_W'(RST_RELEASE));
                write_reg(REG_FLOOR, RST_FLOOR);
                write_reg(REG_GAIN, RST_GAIN);
            end
            1:
            begin
                write_reg(REG_ATTACK, 17'd65536);
                write_reg(REG_DECAY, 17'd65535);
                write_reg(REG_SUSTAIN, 17'd65536);
                write_reg(REG_RELEASE, 17'd65535);
                write_reg(REG_FLOOR, 17'd65536);
                write_reg(REG_GAIN, 17'd65536);
            end
            2:
            begin
                write_reg(REG_ATTACK, 17'd0);
                write_reg(REG_DECAY, 17'd0);
                write_reg(REG_SUSTAIN, 17'd0);
                write_reg(REG_RELEASE, 17'd0);
                write_reg(REG_FLOOR, 17'd0);
                write_reg(REG_GAIN, 17'd0);
            end
            3:
            begin
                write_reg(REG_ATTACK, 17'd9000);
                write_reg(REG_DECAY, 17'd60000);
                write_reg(REG_SUSTAIN, 17'd30000);
                write_reg(REG_RELEASE, 17'd50000);
                write_reg(REG_FLOOR, 17'd0);
                write_reg(REG_GAIN, 17'd65536);
            end
            default:
            begin
                write_reg(REG_ATTACK, CFG_DATA_W'($urandom_range(0, 65536)));
                write_reg(REG_DECAY, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_SUSTAIN, CFG_DATA_W'($urandom_range(0, 65536)));
                write_reg(REG_RELEASE, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_FLOOR, CFG_DATA_W'($urandom_range(0, 65536)));
                write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(0, 65536)));
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 131071)));
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Main stimulus.
    initial
    begin
        int r;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset settings: edge notes, ignored command,
        // restart of a sounding voice and release.
        send_word(CMD_ON, 7'd0);
        send_word(CMD_ON, 7'd127);
        send_word(CMD_TICK, 7'd0);
        send_word(CMD_TICK, 7'd127);
        send_word(CMD_ON, 7'd60);
        send_word(CMD_SPARE, 7'd5);
        send_word(CMD_TICK, 7'd85);
        send_word(CMD_OFF, 7'd0);
        send_word(CMD_TICK, 7'd42);
        send_word(CMD_ON, 7'd127);
        send_word(CMD_TICK, 7'd0);
        send_word(CMD_OFF, 7'd127);
        send_word(CMD_OFF, 7'd60);
        send_word(CMD_OFF, 7'd99);
        send_word(CMD_TICK, 7'd127);
        send_word(CMD_TICK, 7'd0);
        idle_gap(1);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            load_settings(p);
            if (p == PHASES - 1)
                idle_on = 1'b0;
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    send_word(CMD_TICK, 7'($urandom_range(0, 127)));
                else if (r < 72)
                    send_word(CMD_ON, 7'($urandom_range(0, 127)));
                else if (r < 97)
                    send_word(CMD_OFF, 7'($urandom_range(0, 127)));
                else
                    send_word(CMD_SPARE, 7'($urandom_range(0, 127)));
                if (p == 3 && i == PHASE_WORDS / 2)
                begin
                    // Hold the sender until every sample is out.
                    idle_gap(1);
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
                else if (idle_on && $urandom_range(0, 3) == 0)
                    idle_gap($urandom_range(1, 8));
            end
            idle_gap(1);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
